// ===== sv/lr_pkg.sv =====
package lr_pkg;

  // default tile side in address bits
  localparam int unsigned CoordBitsDef = 6;

  // color passed through to every pixel
  localparam int unsigned ColorBits = 24;

  // line case codes
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_SHALLOW_DOWN = 2'd1,
    OCT_STEEP_UP     = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } octant_e;

  // decision update request from the sequencer
  typedef struct packed {
    octant_e octant;
  } dec_ctrl_t;

endpackage

// ===== sv/lr_dec_unit.sv =====
module lr_dec_unit
  import lr_pkg::*;
#(
  parameter int unsigned DecBits = 10
) (
  input  dec_ctrl_t                  ctrl_i,
  input  logic signed [DecBits-1:0]  dec_i,
  input  logic signed [DecBits-1:0]  inc_keep_i,
  input  logic signed [DecBits-1:0]  inc_step_i,
  output logic                       minor_step_o,
  output logic signed [DecBits-1:0]  dec_o
);

  logic dec_pos;
  logic dec_neg;

  assign dec_pos = (dec_i > 0);
  assign dec_neg = dec_i[DecBits-1];

  // minor axis step test depends on the line case
  always_comb begin
    case (ctrl_i.octant)
      OCT_SHALLOW_UP:   minor_step_o = dec_pos;
      OCT_SHALLOW_DOWN: minor_step_o = dec_neg;
      OCT_STEEP_UP:     minor_step_o = dec_neg;
      OCT_STEEP_DOWN:   minor_step_o = dec_pos;
      default:          minor_step_o = 1'b0;
    endcase
  end

  // one shared adder for the decision update
  assign dec_o = dec_i + (minor_step_o ? inc_step_i : inc_keep_i);

endmodule

// ===== sv/line_rasterizer_core.sv =====
// Line rasterizer: midpoint line generator for a square tile.
// Input stream (s_axis): one request per segment, two endpoints and a color.
// Output stream (m_axis): one request per pixel in drawing order, x never falling;
// tlast marks the far endpoint, which always comes last.
// Timing: a segment is accepted only while the core is idle. The IDLE
// state latches and orders the endpoints, the SETUP state sets up the line
// case and the decision term, then the RUN state loads one pixel per cycle
// into the output register while that register is free, through a single
// shared decision adder. A segment whose major axis spans N steps gives
// N+1 pixels; tready stays low from SETUP until the last pixel is loaded,
// so no new segment is taken while one is being drawn.
// The output sits in a register; while the receiver holds tready low the
// sequencer waits and no pixel is lost. After the last pixel is loaded,
// the next segment may be taken even if that pixel is still waiting.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle.
module line_rasterizer_core
  import lr_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned InBits  = ((4 * COORD_BITS + ColorBits + 7) / 8) * 8,
  localparam int unsigned OutBits = ((2 * COORD_BITS + ColorBits + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color, zero pad
  input  logic [InBits-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [OutBits-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  state_e                state_q, state_d;
  logic [C-1:0]          cur_x_q, cur_x_d;
  logic [C-1:0]          cur_y_q, cur_y_d;
  logic [C-1:0]          tgt_x_q, tgt_x_d;
  logic [C-1:0]          tgt_y_q, tgt_y_d;
  logic [ColorBits-1:0]  color_q, color_d;
  octant_e               oct_q, oct_d;
  logic signed [DW-1:0]  dec_q, dec_d;
  logic signed [DW-1:0]  inc_keep_q, inc_keep_d;
  logic signed [DW-1:0]  inc_step_q, inc_step_d;
  logic                  out_valid_q, out_valid_d;
  logic [C-1:0]          out_x_q, out_x_d;
  logic [C-1:0]          out_y_q, out_y_d;
  logic [ColorBits-1:0]  out_color_q, out_color_d;
  logic                  out_last_q, out_last_d;

  // input fields
  logic [C-1:0]          in_sx, in_sy, in_ex, in_ey;
  logic [ColorBits-1:0]  in_color;
  logic                  in_swap;

  // setup arithmetic
  logic [C-1:0]          dx;
  logic signed [C:0]     dy;
  logic [C:0]            ady;
  logic signed [DW-1:0]  dx1, dy1, dx2, dy2;

  // shared decision unit
  dec_ctrl_t             dec_ctrl;
  logic                  minor_step;
  logic signed [DW-1:0]  dec_next;
  logic                  major_done;
  logic                  slot_free;

  assign in_sx    = s_axis_tdata[C-1:0];
  assign in_sy    = s_axis_tdata[2*C-1:C];
  assign in_ex    = s_axis_tdata[3*C-1:2*C];
  assign in_ey    = s_axis_tdata[4*C-1:3*C];
  assign in_color = s_axis_tdata[4*C+ColorBits-1:4*C];
  assign in_swap  = (in_sx > in_ex);

  // deltas from the ordered endpoints
  assign dx  = tgt_x_q - cur_x_q;
  assign dy  = $signed({1'b0, tgt_y_q}) - $signed({1'b0, cur_y_q});
  assign ady = dy[C] ? (C+1)'(-dy) : dy;
  assign dx1 = $signed({{(DW-C){1'b0}}, dx});
  assign dy1 = $signed({{(DW-C-1){dy[C]}}, dy});
  assign dx2 = dx1 <<< 1;
  assign dy2 = dy1 <<< 1;

  assign dec_ctrl.octant = oct_q;

  lr_dec_unit #(
    .DecBits(DW)
  ) u_dec (
    .ctrl_i      (dec_ctrl),
    .dec_i       (dec_q),
    .inc_keep_i  (inc_keep_q),
    .inc_step_i  (inc_step_q),
    .minor_step_o(minor_step),
    .dec_o       (dec_next)
  );

  assign slot_free  = !out_valid_q || m_axis_tready;
  assign major_done = (oct_q == OCT_SHALLOW_UP || oct_q == OCT_SHALLOW_DOWN) ?
                      (cur_x_q == tgt_x_q) : (cur_y_q == tgt_y_q);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    color_d     = color_q;
    oct_d       = oct_q;
    dec_d       = dec_q;
    inc_keep_d  = inc_keep_q;
    inc_step_d  = inc_step_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cur_x_d = in_swap ? in_ex : in_sx;
          cur_y_d = in_swap ? in_ey : in_sy;
          tgt_x_d = in_swap ? in_sx : in_ex;
          tgt_y_d = in_swap ? in_sy : in_ey;
          color_d = in_color;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if ({1'b0, dx} >= ady) begin
          if (dy > 0) begin
            oct_d      = OCT_SHALLOW_UP;
            dec_d      = dy2 - dx1;
            inc_keep_d = dy2;
            inc_step_d = dy2 - dx2;
          end else begin
            oct_d      = OCT_SHALLOW_DOWN;
            dec_d      = dy2 + dx1;
            inc_keep_d = dy2;
            inc_step_d = dy2 + dx2;
          end
        end else begin
          if (dy > 0) begin
            oct_d      = OCT_STEEP_UP;
            dec_d      = dy1 - dx2;
            inc_keep_d = -dx2;
            inc_step_d = dy2 - dx2;
          end else begin
            oct_d      = OCT_STEEP_DOWN;
            dec_d      = dy1 + dx2;
            inc_keep_d = dx2;
            inc_step_d = dy2 + dx2;
          end
        end
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_color_d = color_q;
          if (major_done) begin
            out_x_d    = tgt_x_q;
            out_y_d    = tgt_y_q;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            out_x_d    = cur_x_q;
            out_y_d    = cur_y_q;
            out_last_d = 1'b0;
            dec_d      = dec_next;
            case (oct_q)
              OCT_SHALLOW_UP: begin
                cur_x_d = cur_x_q + 1'b1;
                if (minor_step) cur_y_d = cur_y_q + 1'b1;
              end
              OCT_SHALLOW_DOWN: begin
                cur_x_d = cur_x_q + 1'b1;
                if (minor_step) cur_y_d = cur_y_q - 1'b1;
              end
              OCT_STEEP_UP: begin
                cur_y_d = cur_y_q + 1'b1;
                if (minor_step) cur_x_d = cur_x_q + 1'b1;
              end
              OCT_STEEP_DOWN: begin
                cur_y_d = cur_y_q - 1'b1;
                if (minor_step) cur_x_d = cur_x_q + 1'b1;
              end
              default: begin
                cur_x_d = cur_x_q;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      color_q     <= '0;
      oct_q       <= OCT_SHALLOW_UP;
      dec_q       <= '0;
      inc_keep_q  <= '0;
      inc_step_q  <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_color_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      color_q     <= color_d;
      oct_q       <= oct_d;
      dec_q       <= dec_d;
      inc_keep_q  <= inc_keep_d;
      inc_step_q  <= inc_step_d;
      out_valid_q <= out_valid_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_color_q <= out_color_d;
      out_last_q  <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBits'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;

endmodule
